[rtl/qph_pkg.sv]
`default_nettype none

package qph_pkg;

    localparam int CAPACITY     = 1024;
    localparam int KEY_BITS     = 32;
    localparam int ADDR_BITS    = $clog2(CAPACITY);
    localparam int SIZE_BITS    = ADDR_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(KEY_BITS);

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1021);

    localparam logic [1:0] MARK_EMPTY    = 2'd0;
    localparam logic [1:0] MARK_OCCUPIED = 2'd1;
    localparam logic [1:0] MARK_DELETED  = 2'd2;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_INSERTED  = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_LIMIT     = 3'd4;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [KEY_BITS-1:0] key;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [ADDR_BITS-1:0] position;
        logic [2:0]           status;
    } t_rsp;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [1:0]          mark;
    } t_cell;

    typedef struct packed {
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        t_cell                wdata;
    } t_mem_cmd;

endpackage

`default_nettype wire

[rtl/qph_mod_unit.sv]
`default_nettype none

module qph_mod_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire [qph_pkg::KEY_BITS-1:0]   i_dividend,
    input  wire [qph_pkg::SIZE_BITS-1:0]  i_divisor,
    output logic                          o_done,
    output logic [qph_pkg::ADDR_BITS-1:0] o_rem
);
    import qph_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [KEY_BITS-1:0]     r_dvd;
    logic [SIZE_BITS-1:0]    r_div;
    logic [ADDR_BITS-1:0]    r_rem;
    logic [SIZE_BITS-1:0]    w_trial;
    logic [SIZE_BITS-1:0]    w_diff;
    logic [ADDR_BITS-1:0]    n_rem;

    // Restoring remainder: one dividend bit per cycle, MSB first. The
    // partial remainder stays below the divisor, so one subtract suffices.
    always_comb begin
        w_trial = {r_rem, r_dvd[KEY_BITS-1]};
        w_diff  = w_trial - r_div;
        if (w_trial >= r_div) begin
            n_rem = w_diff[ADDR_BITS-1:0];
        end else begin
            n_rem = w_trial[ADDR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(KEY_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[KEY_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({1'b0, r_rem} < r_div))
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("done without a running division");

    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while still busy");

endmodule

`default_nettype wire

[rtl/qph_cell_mem.sv]
`default_nettype none

module qph_cell_mem (
    input  wire                       i_clk,
    input  wire qph_pkg::t_mem_cmd    i_cmd,
    output qph_pkg::t_cell            o_rd
);
    import qph_pkg::*;

    t_cell r_mem [CAPACITY];
    t_cell r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rd <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

[rtl/quadratic_probe_hash_set.sv]
`default_nettype none

// Flow: an accepted word first goes through the serial key-mod-size remainder,
// then through P probes, where P is the number of cells probed (1 to table_size),
// each probe being one table read plus one check, and then waits in the done
// state until the output register is free. The input stalls until the sequencer
// is idle again, so a new word is taken only after the last result is registered.
// Reset: synchronous, active low; a clearing pass then marks all 1024 cells
// empty, and the input stalls until it is done.
module quadratic_probe_hash_set (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire qph_pkg::t_req           i_in_req,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output qph_pkg::t_rsp                o_out_rsp,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [qph_pkg::SIZE_BITS-1:0] i_cfg_data
);
    import qph_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]           r_state;
    logic [SIZE_BITS-1:0] r_table_size;
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic [1:0]           r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [ADDR_BITS-1:0] r_pos;
    logic [SIZE_BITS-1:0] r_inc;
    logic [SIZE_BITS-1:0] r_probes;
    logic                 r_res_hit;
    logic [2:0]           r_res_status;
    logic                 r_out_valid;
    t_rsp                 r_out_rsp;

    logic [SIZE_BITS-1:0] w_size;
    logic                 w_accept;
    logic                 w_div_done;
    logic [ADDR_BITS-1:0] w_div_rem;
    t_cell                w_rd;
    t_mem_cmd             w_cmd;
    logic                 w_stop;
    logic                 w_present;
    logic [SIZE_BITS-1:0] w_probes_n;
    logic [SIZE_BITS-1:0] w_sum;
    logic [SIZE_BITS-1:0] w_sum_red;
    logic [SIZE_BITS-1:0] w_inc2;
    logic [SIZE_BITS-1:0] w_inc_red;
    logic                 w_out_free;

    always_comb begin
        if (r_table_size == '0) begin
            w_size = SIZE_BITS'(1);
        end else if (r_table_size > SIZE_BITS'(CAPACITY)) begin
            w_size = SIZE_BITS'(CAPACITY);
        end else begin
            w_size = r_table_size;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    qph_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_in_req.key),
        .i_divisor  (w_size),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    qph_cell_mem u_mem (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .o_rd  (w_rd)
    );

    // Probe check. Increments are kept reduced mod size, so each advance
    // needs only one conditional subtract (size is at least two here).
    always_comb begin
        w_stop     = (w_rd.mark == MARK_EMPTY) || (w_rd.key == r_key);
        w_present  = (w_rd.mark == MARK_OCCUPIED);
        w_probes_n = r_probes + 1'b1;
        w_sum      = {1'b0, r_pos} + r_inc;
        w_sum_red  = (w_sum >= w_size) ? (w_sum - w_size) : w_sum;
        w_inc2     = r_inc + SIZE_BITS'(2);
        w_inc_red  = (w_inc2 >= w_size) ? (w_inc2 - w_size) : w_inc2;
    end

    always_comb begin
        w_cmd       = '0;
        w_cmd.raddr = r_pos;
        w_cmd.re    = (r_state == S_READ);
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.we         = 1'b1;
                w_cmd.waddr      = r_clr_addr;
                w_cmd.wdata.key  = '0;
                w_cmd.wdata.mark = MARK_EMPTY;
            end
            S_CHECK: begin
                w_cmd.waddr = r_pos;
                if (w_stop && (r_op == REQ_INSERT) && !w_present) begin
                    w_cmd.we         = 1'b1;
                    w_cmd.wdata.key  = r_key;
                    w_cmd.wdata.mark = MARK_OCCUPIED;
                end else if (w_stop && (r_op == REQ_DELETE) && w_present) begin
                    w_cmd.we         = 1'b1;
                    w_cmd.wdata.key  = w_rd.key;
                    w_cmd.wdata.mark = MARK_DELETED;
                end
            end
            default: begin
                w_cmd.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_BITS'(CAPACITY - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_div_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (w_stop || (w_probes_n >= w_size)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in_req.req_type;
            r_key <= i_in_req.key;
        end
        if ((r_state == S_HASH) && w_div_done) begin
            r_pos    <= w_div_rem;
            r_inc    <= SIZE_BITS'(1);
            r_probes <= '0;
        end
        if (r_state == S_CHECK) begin
            r_probes <= w_probes_n;
            if (w_stop) begin
                r_res_hit <= w_present;
                case (r_op)
                    REQ_INSERT: r_res_status <= w_present ? ST_FOUND : ST_INSERTED;
                    REQ_DELETE: r_res_status <= w_present ? ST_DELETED : ST_NOT_FOUND;
                    default:    r_res_status <= w_present ? ST_FOUND : ST_NOT_FOUND;
                endcase
            end else if (w_probes_n >= w_size) begin
                r_res_hit    <= 1'b0;
                r_res_status <= ST_LIMIT;
            end else begin
                r_pos <= w_sum_red[ADDR_BITS-1:0];
                r_inc <= w_inc_red;
            end
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_rsp.hit      <= r_res_hit;
            r_out_rsp.position <= r_pos;
            r_out_rsp.status   <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result word raised outside the done state");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_probes < w_size))
        else $error("probe count reached table size without stopping");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ({1'b0, r_pos} < w_size))
        else $error("probe position outside the table");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_HASH || r_state == S_DONE) |-> !w_cmd.we)
        else $error("table written outside clear or check");

endmodule

`default_nettype wire

[sim/quadratic_probe_hash_set_tb.sv]
`timescale 1ns / 1ps

module quadratic_probe_hash_set_tb;
    import qph_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned KEY_POOL_SIZE  = 16;
    localparam int unsigned PHASE_ITEMS    = 50;
    localparam logic [1:0]  REQ_SPARE      = 2'd3;

    // Mirror of the table contents and the size register, fed by accepted words and size writes.
    class probe_table_tracker;
        logic [SIZE_BITS-1:0] size_reg;
        logic [KEY_BITS-1:0]  cell_key[CAPACITY];
        logic [1:0]           cell_mark[CAPACITY];
        t_rsp                 expected_rsp[$];
        int unsigned          failures;

        function new();
            size_reg = SIZE_RESET;
            failures = 0;
            foreach (cell_mark[i]) begin
                cell_mark[i] = MARK_EMPTY;
                cell_key[i]  = '0;
            end
        endfunction

        function void write_size(logic [SIZE_BITS-1:0] value);
            size_reg = value;
        endfunction

        function void note_request(t_req req);
            int unsigned span;
            int unsigned pos;
            int unsigned probes;
            bit          stopped;
            bit          present;
            t_rsp        rsp;
            span = size_reg;
            if (span == 0) span = 1;
            if (span > CAPACITY) span = CAPACITY;
            pos = req.key % span;
            probes = 0;
            stopped = 0;
            while (probes < span && !stopped) begin
                probes++;
                if (cell_mark[pos] == MARK_EMPTY || cell_key[pos] == req.key) begin
                    stopped = 1;
                end else if (probes < span) begin
                    pos = (pos + 2 * probes - 1) % span;
                end
            end
            rsp.position = pos[ADDR_BITS-1:0];
            rsp.hit = 1'b0;
            if (!stopped) begin
                rsp.status = ST_LIMIT;
            end else begin
                present = (cell_mark[pos] == MARK_OCCUPIED);
                rsp.hit = present;
                if (req.req_type == REQ_INSERT) begin
                    if (present) begin
                        rsp.status = ST_FOUND;
                    end else begin
                        // The stop cell is empty or a deleted copy of the same key.
                        cell_key[pos]  = req.key;
                        cell_mark[pos] = MARK_OCCUPIED;
                        rsp.status = ST_INSERTED;
                    end
                end else if (req.req_type == REQ_DELETE) begin
                    if (present) begin
                        cell_mark[pos] = MARK_DELETED;
                        rsp.status = ST_DELETED;
                    end else begin
                        rsp.status = ST_NOT_FOUND;
                    end
                end else begin
                    rsp.status = present ? ST_FOUND : ST_NOT_FOUND;
                end
            end
            expected_rsp.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result word: hit %0d position %0d status %0d",
                         $time, got.hit, got.position, got.status);
                failures++;
            end else begin
                want = expected_rsp.pop_front();
                if (got.hit !== want.hit) begin
                    $display("%0t: hit mismatch: expected %0d, actual %0d",
                             $time, want.hit, got.hit);
                    failures++;
                end
                if (got.position !== want.position) begin
                    $display("%0t: position mismatch: expected %0d, actual %0d",
                             $time, want.position, got.position);
                    failures++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got.status);
                    failures++;
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_req                 i_in_req;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_rsp                 o_out_rsp;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [SIZE_BITS-1:0] i_cfg_data;

    probe_table_tracker   table_tracker = new();
    int unsigned          send_idle_pct = 0;
    int unsigned          stall_pct = 0;
    int unsigned          quiet_cycles = 0;
    logic [KEY_BITS-1:0]  key_pool[KEY_POOL_SIZE];

    quadratic_probe_hash_set DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            table_tracker.check_response(o_out_rsp);
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            table_tracker.note_request(i_in_req);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            table_tracker.write_size(i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(input logic [1:0] op, input logic [KEY_BITS-1:0] key);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= '{req_type: op, key: key};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (table_tracker.expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [SIZE_BITS-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_req();
        logic [1:0]          op;
        logic [KEY_BITS-1:0] key;
        int unsigned         pick;
        pick = $urandom_range(99);
        if (pick < 35) op = REQ_LOOKUP;
        else if (pick < 70) op = REQ_INSERT;
        else if (pick < 95) op = REQ_DELETE;
        else op = REQ_SPARE;
        // Mostly reuse a small set of keys so that hits, deletes and full tables occur.
        if ($urandom_range(99) < 75) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        else key = $urandom();
        send_req(op, key);
    endtask

    initial begin
        logic [SIZE_BITS-1:0] phase_size[8];
        phase_size = '{11'd3, 11'd1024, 11'd2, 11'd7, 11'd1021, 11'd13, 11'd31, 11'd97};

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size: collisions, reuse of a deleted cell, key extremes.
        send_req(REQ_LOOKUP, 32'd0);
        send_req(REQ_INSERT, 32'd0);
        send_req(REQ_INSERT, 32'd0);
        send_req(REQ_INSERT, 32'hFFFF_FFFF);
        send_req(REQ_LOOKUP, 32'hFFFF_FFFF);
        send_req(REQ_INSERT, 32'd1021);
        send_req(REQ_DELETE, 32'd0);
        send_req(REQ_LOOKUP, 32'd1021);
        send_req(REQ_INSERT, 32'd0);
        send_req(REQ_DELETE, 32'd12345);
        send_req(REQ_SPARE, 32'd1021);
        send_req(REQ_DELETE, 32'd1021);

        // Two cells: fill them, then run into the probe limit past a deleted cell.
        write_table_size(11'd2);
        send_req(REQ_INSERT, 32'd4);
        send_req(REQ_INSERT, 32'd7);
        send_req(REQ_INSERT, 32'd10);
        send_req(REQ_DELETE, 32'd4);
        send_req(REQ_INSERT, 32'd10);
        send_req(REQ_LOOKUP, 32'd7);

        // A size of zero behaves as one cell.
        write_table_size(11'd0);
        send_req(REQ_INSERT, 32'd5);
        send_req(REQ_LOOKUP, 32'd4);
        send_req(REQ_INSERT, 32'd4);

        // An oversized value saturates to the full capacity.
        write_table_size(11'h7FF);
        send_req(REQ_INSERT, 32'hFFFF_FFFF);
        send_req(REQ_LOOKUP, 32'hFFFF_FFFF);
        send_req(REQ_DELETE, 32'hFFFF_FFFF);
        send_req(REQ_LOOKUP, 32'h8000_0000);

        for (int phase = 0; phase < 8; phase++) begin
            write_table_size(phase_size[phase]);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 62;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 62;
                end
                default: begin
                    send_idle_pct = 15;
                    stall_pct = 15;
                end
            endcase
            for (int i = 0; i < KEY_POOL_SIZE; i++) begin
                key_pool[i] = (i < 6) ? KEY_BITS'($urandom_range(40)) : $urandom();
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) wait_drained();
                send_random_req();
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (table_tracker.failures == 0 && table_tracker.expected_rsp.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/qph_pkg.sv
rtl/qph_mod_unit.sv
rtl/qph_cell_mem.sv
rtl/quadratic_probe_hash_set.sv
sim/quadratic_probe_hash_set_tb.sv
